// ===== rtl/spf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, byte codes and helpers for the stuffed packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_ESC = 8'h1b;

    // Longest word list: STX, length low, length high, ETX, checksum
    localparam int unsigned NUM_SYMS  = 5;
    localparam int unsigned SYM_IDX_W = 3;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // One queued job: a short list of logical bytes for the back end
    typedef struct packed {
        logic                       err;
        logic                       trailer;
        logic [SYM_IDX_W-1:0]       count;
        logic [NUM_SYMS-1:0]        esc;
        logic [NUM_SYMS-1:0][7:0]   sym;
    } desc_t;

    function automatic logic needs_escape(input logic [7:0] b);
        logic hit;
        hit = (b == 8'h02) || (b == 8'h03) || (b == 8'h05) ||
              (b == 8'h06) || (b == 8'h11) || (b == BYTE_ESC);
        return hit;
    endfunction

endpackage

// ===== rtl/spf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_front
// Accepts input words, tracks packet state and queues a byte list per word.
// ----------------------------------------------------------------------------
module spf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [15:0]         payload_length,
    input  logic [7:0]          data_byte,
    input  logic                q_full,
    output logic                push,
    output spf_pkg::desc_t      desc
);

    logic        open_reg,  open_next;
    logic [15:0] rem_reg,   rem_next;
    logic [7:0]  sum_reg,   sum_next;

    logic [7:0]  len_lo;
    logic [7:0]  len_hi;
    logic        len_zero;
    logic [7:0]  sum_start;
    logic [7:0]  sum_data;
    logic        rem_last;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign len_lo    = payload_length[7:0];
    assign len_hi    = payload_length[15:8];
    assign len_zero  = (payload_length == 16'd0);
    assign sum_start = len_lo + len_hi;
    assign sum_data  = sum_reg + data_byte;
    assign rem_last  = (rem_reg == 16'd1);

    always_comb
    begin
        open_next = open_reg;
        rem_next  = rem_reg;
        sum_next  = sum_reg;
        desc      = '0;
        priority if (opcode == spf_pkg::OP_START)
        begin
            sum_next     = len_zero ? (sum_start + spf_pkg::BYTE_ETX) : sum_start;
            rem_next     = payload_length;
            open_next    = !len_zero;
            desc.sym[0]  = spf_pkg::BYTE_STX;
            desc.sym[1]  = len_lo;
            desc.sym[2]  = len_hi;
            desc.sym[3]  = spf_pkg::BYTE_ETX;
            desc.sym[4]  = sum_next;
            desc.esc[1]  = spf_pkg::needs_escape(len_lo);
            desc.esc[2]  = spf_pkg::needs_escape(len_hi);
            desc.esc[4]  = spf_pkg::needs_escape(sum_next);
            desc.trailer = len_zero;
            desc.count   = len_zero ? spf_pkg::SYM_IDX_W'(5) : spf_pkg::SYM_IDX_W'(3);
        end
        else if (open_reg)
        begin
            sum_next     = rem_last ? (sum_data + spf_pkg::BYTE_ETX) : sum_data;
            rem_next     = rem_reg - 16'd1;
            open_next    = !rem_last;
            desc.sym[0]  = data_byte;
            desc.sym[1]  = spf_pkg::BYTE_ETX;
            desc.sym[2]  = sum_next;
            desc.esc[0]  = spf_pkg::needs_escape(data_byte);
            desc.esc[2]  = spf_pkg::needs_escape(sum_next);
            desc.trailer = rem_last;
            desc.count   = rem_last ? spf_pkg::SYM_IDX_W'(3) : spf_pkg::SYM_IDX_W'(1);
        end
        else
        begin
            // data with no open packet: single error word, state untouched
            desc.err   = 1'b1;
            desc.count = spf_pkg::SYM_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= 16'd0;
            sum_reg  <= 8'd0;
        end
        else if (push)
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

// ===== rtl/spf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_queue
// Small FIFO of byte-list jobs between the front and back ends.
// ----------------------------------------------------------------------------
module spf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spf_pkg::desc_t      wr_desc,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output spf_pkg::desc_t      rd_desc
);

    spf_pkg::desc_t                 mem_reg [spf_pkg::QUEUE_DEPTH];
    logic [spf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [spf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [spf_pkg::QCNT_W-1:0]     cnt_reg,    cnt_next;

    assign full    = (cnt_reg == spf_pkg::QCNT_W'(spf_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg + spf_pkg::QCNT_W'(push) - spf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/spf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_back
// Walks a queued byte list, inserts escape bytes and drives the output register.
// ----------------------------------------------------------------------------
module spf_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  spf_pkg::desc_t      head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          line_byte,
    output logic                last_of_run,
    output logic                frame_end,
    output logic                error
);

    logic [spf_pkg::SYM_IDX_W-1:0]  idx_reg,  idx_next;
    logic                           half_reg, half_next;
    logic                           valid_reg;
    logic [7:0]                     byte_reg;
    logic                           last_reg;
    logic                           fend_reg;
    logic                           err_reg;

    logic                           can_load;
    logic                           load;
    logic [7:0]                     cur_sym;
    logic                           cur_esc;
    logic [7:0]                     cur_byte;
    logic                           sym_done;
    logic                           job_done;

    assign can_load = !valid_reg || out_ready;
    assign load     = can_load && !q_empty;
    assign cur_sym  = head.sym[idx_reg];
    assign cur_esc  = head.esc[idx_reg];
    assign sym_done = half_reg || !cur_esc;
    assign job_done = sym_done && (idx_reg == (head.count - 1'b1));
    assign pop      = load && job_done;

    always_comb
    begin
        priority if (half_reg)
        begin
            cur_byte = ~cur_sym;
        end
        else if (cur_esc)
        begin
            cur_byte = spf_pkg::BYTE_ESC;
        end
        else
        begin
            cur_byte = cur_sym;
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        half_next = half_reg;
        if (load)
        begin
            priority if (!sym_done)
            begin
                half_next = 1'b1;
            end
            else if (job_done)
            begin
                half_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                half_next = 1'b0;
                idx_next  = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            half_reg <= half_next;
            if (can_load)
            begin
                valid_reg <= !q_empty;
            end
        end
    end

    // hold the word while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.err ? 8'h00 : cur_byte;
            last_reg <= job_done;
            fend_reg <= job_done && head.trailer;
            err_reg  <= head.err;
        end
    end

    assign out_valid   = valid_reg;
    assign line_byte   = byte_reg;
    assign last_of_run = last_reg;
    assign frame_end   = fend_reg;
    assign error       = err_reg;

endmodule

// ===== rtl/stuffed_packet_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_packet_framer_unit
// Byte-stuffing packet framer: STX, length, escaped payload, ETX, checksum.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode start carries payload_length,
// opcode data carries one payload byte in data_byte.
// Output channel (out_valid/out_ready): one line byte per word, with
// last_of_run on the final word of an input item, frame_end on the last
// checksum byte and error on the single word answering data with no packet.
// An accepted item is written into the job queue; its first line byte is
// then loaded into the output register, from which the receiver takes it.
// Throughput: one line byte per cycle from the output register while the
// receiver is ready; an item yields 1 to 5 line bytes for a payload byte,
// 3 to 5 for a start and 6 for a start with zero length.
// Unless the queue is full, the front end decodes one item per cycle into a
// two-entry job queue, so input is taken while the back end expands escapes.
// Reset clears the packet state, the queue and the output valid.
// When the receiver stalls, the output word holds, the back end stops and
// in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module stuffed_packet_framer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] payload_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  line_byte,
    output logic        last_of_run,
    output logic        frame_end,
    output logic        error
);

    spf_pkg::desc_t wr_desc;
    spf_pkg::desc_t rd_desc;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    spf_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .push           (push),
        .desc           (wr_desc)
    );

    spf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .full    (q_full),
        .empty   (q_empty),
        .rd_desc (rd_desc)
    );

    spf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (rd_desc),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_byte   (line_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .error       (error)
    );

endmodule
